// ===== rtl/bmrh_pkg.sv =====
`timescale 1ns / 1ps

package bmrh_pkg;

    // Fixed field widths
    localparam int WORD_W     = 32;
    localparam int RANK_OUT_W = 6;
    localparam int TALLY_W    = 24;
    localparam int GEO_W      = 6;
    localparam int SHIFT_W    = 5;
    localparam int GOAL_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register reset values
    localparam logic [GEO_W-1:0]   ROW_COUNT_RST  = 6'd32;
    localparam logic [GEO_W-1:0]   COL_COUNT_RST  = 6'd32;
    localparam logic [SHIFT_W-1:0] WORD_SHIFT_RST = 5'd0;
    localparam logic [GOAL_W-1:0]  GOAL_RST       = 24'd38;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT   = 3'd0,
        CFG_COL_COUNT   = 3'd1,
        CFG_WORD_MODE   = 3'd2,
        CFG_WORD_SHIFT  = 3'd3,
        CFG_MATRIX_GOAL = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ELIM,
        ST_READ,
        ST_UPD
    } t_state;

endpackage

// ===== rtl/bmrh_in_if.sv =====
`timescale 1ns / 1ps

interface bmrh_in_if;
    import bmrh_pkg::*;

    logic              valid;
    logic              ready;
    logic              stream_bit;
    logic [WORD_W-1:0] stream_word;

    modport source (output valid, output stream_bit, output stream_word, input ready);
    modport sink   (input valid, input stream_bit, input stream_word, output ready);
endinterface

// ===== rtl/bmrh_out_if.sv =====
`timescale 1ns / 1ps

interface bmrh_out_if;
    import bmrh_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [RANK_OUT_W-1:0] matrix_rank;
    logic [TALLY_W-1:0]    rank_tally;
    logic [TALLY_W-1:0]    matrices_done;
    logic                  goal_reached;

    modport source (output valid, output matrix_rank, output rank_tally,
                    output matrices_done, output goal_reached, input ready);
    modport sink   (input valid, input matrix_rank, input rank_tally,
                    input matrices_done, input goal_reached, output ready);
endinterface

// ===== rtl/binary_matrix_rank_histogram_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                                            Handshake
// i_in      in   stream_bit, stream_word                            valid/ready
// o_out     out  matrix_rank, rank_tally, matrices_done,            valid/ready
//                goal_reached
// i_cfg_*   in   i_cfg_idx, i_cfg_data                              i_cfg_we
//
// Fill items are taken whenever the block is idle. The item that completes a matrix
// starts the reduction: one column of GF(2) elimination per cycle on the
// shared pivot/XOR unit, then a read and a write of the histogram memory.
// i_rst_n (synchronous) clears control, config and histogram valid bits.
// Input is held off while a matrix is reduced; a finished item waits in the
// output register while filling continues, and only the next matrix's
// histogram update waits on it.

module binary_matrix_rank_histogram_unit #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int COUNT_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bmrh_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bmrh_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    bmrh_in_if.sink                          i_in,
    bmrh_out_if.source                       o_out
);
    import bmrh_pkg::*;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);
    localparam int COLS_W = $clog2(MAX_COLS + 1);
    localparam int HIST_D = MAX_ROWS + 1;
    localparam int RANK_W = $clog2(HIST_D);

    localparam logic [MAX_COLS-1:0]   COL_TOP = MAX_COLS'(64'd1 << (MAX_COLS - 1));
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // ---------------- configuration ----------------
    logic [GEO_W-1:0]   r_row_count;
    logic [GEO_W-1:0]   r_col_count;
    logic               r_word_mode;
    logic [SHIFT_W-1:0] r_word_shift;
    logic [GOAL_W-1:0]  r_goal;

    logic [ROWS_W-1:0]  eff_rows;
    logic [COLS_W-1:0]  eff_cols;

    // out-of-range counts clamp to 1..MAX
    always_comb begin
        if (r_row_count == '0) begin
            eff_rows = ROWS_W'(1);
        end else if (r_row_count > GEO_W'(MAX_ROWS)) begin
            eff_rows = ROWS_W'(MAX_ROWS);
        end else begin
            eff_rows = ROWS_W'(r_row_count);
        end
        if (r_col_count == '0) begin
            eff_cols = COLS_W'(1);
        end else if (r_col_count > GEO_W'(MAX_COLS)) begin
            eff_cols = COLS_W'(MAX_COLS);
        end else begin
            eff_cols = COLS_W'(r_col_count);
        end
    end

    // ---------------- state ----------------
    t_state              r_state, n_state;
    logic [ROW_W-1:0]    r_fill_row, n_fill_row;
    logic [COL_W-1:0]    r_fill_col, n_fill_col;
    logic [MAX_COLS-1:0] r_acc, n_acc;             // row being assembled in bit mode
    logic [MAX_COLS-1:0] r_rows [MAX_ROWS];        // matrix, one lane per row
    logic [MAX_ROWS-1:0] r_used, n_used;           // rows already taken as pivot
    logic [RANK_W-1:0]   r_rank, n_rank;
    logic [COL_W-1:0]    r_col, n_col;
    logic [MAX_COLS-1:0] r_colmask, n_colmask;     // one-hot current column
    logic [COUNT_BITS-1:0] r_mcount, n_mcount;

    logic [COUNT_BITS-1:0] r_hist [HIST_D];        // histogram memory
    logic [HIST_D-1:0]     r_hist_vld;
    logic [COUNT_BITS-1:0] r_hist_q;
    logic                  r_hist_hit;

    logic                  r_out_valid, n_out_valid;
    logic [RANK_W-1:0]     r_out_rank;
    logic [COUNT_BITS-1:0] r_out_tally;
    logic [COUNT_BITS-1:0] r_out_done;
    logic                  r_out_goal;

    // ---------------- elimination unit ----------------
    logic [MAX_ROWS-1:0] lane_on;
    logic [MAX_ROWS-1:0] cand;
    logic [MAX_ROWS-1:0] pick;
    logic [MAX_COLS-1:0] pivot;

    always_comb begin
        pivot = '0;
        for (int i = 0; i < MAX_ROWS; i++) begin
            lane_on[i] = 32'(i) < 32'(eff_rows);
            cand[i]    = lane_on[i] && !r_used[i] && (|(r_rows[i] & r_colmask));
        end
        // lowest candidate row becomes the pivot
        pick = cand & (~cand + MAX_ROWS'(1));
        for (int i = 0; i < MAX_ROWS; i++) begin
            pivot = pivot | (r_rows[i] & {MAX_COLS{pick[i]}});
        end
    end

    // ---------------- sequencer ----------------
    logic                  goal_met;
    logic                  out_free;
    logic [ROW_W-1:0]      row_idx;
    logic [COL_W-1:0]      col_idx;
    logic                  row_last;
    logic                  col_last;
    logic [WORD_W-1:0]     shifted;
    logic [MAX_COLS-1:0]   acc_base;
    logic                  row_we;
    logic [MAX_COLS-1:0]   row_wdata;
    logic                  hist_we;
    logic [COUNT_BITS-1:0] cur_tally;
    logic [COUNT_BITS-1:0] new_tally;

    assign goal_met = 32'(r_mcount) >= 32'(r_goal);
    assign out_free = !r_out_valid || o_out.ready;
    assign shifted  = i_in.stream_word << r_word_shift;
    assign cur_tally = r_hist_hit ? r_hist_q : '0;
    assign new_tally = (cur_tally == CNT_MAX) ? cur_tally : cur_tally + COUNT_BITS'(1);

    always_comb begin
        n_state     = r_state;
        n_fill_row  = r_fill_row;
        n_fill_col  = r_fill_col;
        n_acc       = r_acc;
        n_used      = r_used;
        n_rank      = r_rank;
        n_col       = r_col;
        n_colmask   = r_colmask;
        n_mcount    = r_mcount;
        n_out_valid = r_out_valid;
        row_we      = 1'b0;
        row_wdata   = shifted[WORD_W-1 -: MAX_COLS];
        hist_we     = 1'b0;
        acc_base    = '0;

        // stale position after a geometry change starts over
        if ((32'(r_fill_row) >= 32'(eff_rows)) || (32'(r_fill_col) >= 32'(eff_cols))) begin
            row_idx = '0;
            col_idx = '0;
        end else begin
            row_idx = r_fill_row;
            col_idx = r_fill_col;
        end
        row_last = 32'(row_idx) == 32'(eff_rows) - 32'd1;
        col_last = 32'(col_idx) == 32'(eff_cols) - 32'd1;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid && !goal_met) begin
                    if (r_word_mode) begin
                        row_we     = 1'b1;
                        n_fill_col = '0;
                        n_fill_row = row_last ? '0 : ROW_W'(row_idx + ROW_W'(1));
                    end else begin
                        acc_base = (col_idx == '0) ? '0 : r_acc;
                        n_acc    = i_in.stream_bit ? (acc_base | (COL_TOP >> col_idx))
                                                   : (acc_base & ~(COL_TOP >> col_idx));
                        row_wdata = n_acc;
                        if (col_last) begin
                            row_we     = 1'b1;
                            n_fill_col = '0;
                            n_fill_row = row_last ? '0 : ROW_W'(row_idx + ROW_W'(1));
                        end else begin
                            n_fill_col = COL_W'(col_idx + COL_W'(1));
                            n_fill_row = row_idx;
                        end
                    end
                    if (row_we && row_last) begin
                        n_state   = ST_ELIM;
                        n_used    = '0;
                        n_rank    = '0;
                        n_col     = '0;
                        n_colmask = COL_TOP;
                    end
                end
            end
            ST_ELIM: begin
                n_used    = r_used | pick;
                n_rank    = (|cand) ? RANK_W'(r_rank + RANK_W'(1)) : r_rank;
                n_colmask = r_colmask >> 1;
                n_col     = COL_W'(r_col + COL_W'(1));
                if (32'(r_col) == 32'(eff_cols) - 32'd1) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) begin
                    hist_we     = 1'b1;
                    n_mcount    = (r_mcount == CNT_MAX) ? r_mcount
                                                        : r_mcount + COUNT_BITS'(1);
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // geometry writes restart the partial matrix
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_COUNT, CFG_COL_COUNT, CFG_WORD_MODE: begin
                    n_fill_row = '0;
                    n_fill_col = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_fill_row   <= '0;
            r_fill_col   <= '0;
            r_mcount     <= '0;
            r_out_valid  <= 1'b0;
            r_hist_vld   <= '0;
            r_row_count  <= ROW_COUNT_RST;
            r_col_count  <= COL_COUNT_RST;
            r_word_mode  <= 1'b0;
            r_word_shift <= WORD_SHIFT_RST;
            r_goal       <= GOAL_RST;
        end else begin
            r_state     <= n_state;
            r_fill_row  <= n_fill_row;
            r_fill_col  <= n_fill_col;
            r_mcount    <= n_mcount;
            r_out_valid <= n_out_valid;
            if (hist_we) begin
                r_hist_vld[r_rank] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ROW_COUNT:   r_row_count  <= i_cfg_data[GEO_W-1:0];
                    CFG_COL_COUNT:   r_col_count  <= i_cfg_data[GEO_W-1:0];
                    CFG_WORD_MODE:   r_word_mode  <= i_cfg_data[0];
                    CFG_WORD_SHIFT:  r_word_shift <= i_cfg_data[SHIFT_W-1:0];
                    CFG_MATRIX_GOAL: r_goal       <= i_cfg_data[GOAL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_used    <= n_used;
        r_rank    <= n_rank;
        r_col     <= n_col;
        r_colmask <= n_colmask;
        for (int i = 0; i < MAX_ROWS; i++) begin
            if ((r_state == ST_ELIM) && cand[i] && !pick[i]) begin
                r_rows[i] <= r_rows[i] ^ pivot;
            end else if (row_we && (row_idx == ROW_W'(i))) begin
                r_rows[i] <= row_wdata;
            end
        end
        if (r_state == ST_READ) begin
            r_hist_q   <= r_hist[r_rank];
            r_hist_hit <= r_hist_vld[r_rank];
        end
        if (hist_we) begin
            r_hist[r_rank] <= new_tally;
            r_out_rank     <= r_rank;
            r_out_tally    <= new_tally;
            r_out_done     <= n_mcount;
            r_out_goal     <= 32'(n_mcount) == 32'(r_goal);
        end
    end

    // ---------------- ports ----------------
    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.matrix_rank   = RANK_OUT_W'(r_out_rank);
    assign o_out.rank_tally    = TALLY_W'(r_out_tally);
    assign o_out.matrices_done = TALLY_W'(r_out_done);
    assign o_out.goal_reached  = r_out_goal;

`ifndef SYNTHESIS
    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (32'(r_rank) <= 32'(eff_rows)))
        else $error("rank exceeds active rows");

    a_colmask_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ELIM) |-> $onehot(r_colmask))
        else $error("column select not one-hot during elimination");

    a_used_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> ((r_used & ~lane_on) == '0))
        else $error("pivot taken from inactive row");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_UPD) && out_free) |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("histogram update did not present an item");
`endif

endmodule

// ===== tb/sv/tb_binary_matrix_rank_histogram_unit.sv =====
`timescale 1ns / 1ps

module tb_binary_matrix_rank_histogram_unit;
    import bmrh_pkg::*;

    // Run shape
    localparam int    PHASE_ITEMS   = 190;
    localparam int    NUM_PHASES    = 9;
    localparam int    SETTLE_CYCLES = 48;      // longer than the longest reduction
    localparam int    HOLD_CYCLES   = 400;     // long receiver hold-off
    localparam int    CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic              bit_in;
        logic [WORD_W-1:0] word_in;
    } t_stream_item;

    typedef struct packed {
        logic [RANK_OUT_W-1:0] rank;
        logic [TALLY_W-1:0]    tally;
        logic [TALLY_W-1:0]    done;
        logic                  goal;
    } t_rank_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bmrh_in_if  in_bus ();
    bmrh_out_if out_bus ();

    binary_matrix_rank_histogram_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block: config, matrix being filled, histogram.
    // ------------------------------------------------------------------
    logic [GEO_W-1:0]   cfg_rows;
    logic [GEO_W-1:0]   cfg_cols;
    logic               cfg_word;
    logic [SHIFT_W-1:0] cfg_shift;
    logic [GOAL_W-1:0]  cfg_goal;

    logic [31:0]        mat_rows [32];
    int unsigned        row_pos;
    int unsigned        col_pos;
    logic [TALLY_W-1:0] rank_hist [33];
    logic [TALLY_W-1:0] mat_done;

    t_stream_item stream_backlog [$];   // items still to be offered
    t_rank_result matrix_outcomes [$];  // predicted results, oldest first

    // Traffic shaping, set per phase
    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    logic        hold_start;
    int unsigned hold_left;

    // Stimulus content knobs
    logic [31:0] word_basis [4];
    int unsigned bit_bias;

    int unsigned mismatches;
    int unsigned cycle_count;

    function automatic void predictor_reset();
        cfg_rows  = ROW_COUNT_RST;
        cfg_cols  = COL_COUNT_RST;
        cfg_word  = 1'b0;
        cfg_shift = WORD_SHIFT_RST;
        cfg_goal  = GOAL_RST;
        row_pos   = 0;
        col_pos   = 0;
        mat_done  = '0;
        for (int i = 0; i < 32; i++) mat_rows[i] = '0;
        for (int i = 0; i < 33; i++) rank_hist[i] = '0;
    endfunction

    function automatic int unsigned eff_rows();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > 32) return 32;
        return cfg_rows;
    endfunction

    function automatic int unsigned eff_cols();
        if (cfg_cols == 0) return 1;
        if (cfg_cols > 32) return 32;
        return cfg_cols;
    endfunction

    // Gauss-Jordan elimination over GF(2), leftmost column first
    function automatic int unsigned gf2_rank_of(int unsigned m, int unsigned q);
        logic [31:0] work [32];
        logic [31:0] keep;
        logic [31:0] tmp;
        int unsigned rank;
        int unsigned r;
        keep = 32'hFFFF_FFFF << (32 - q);
        for (int i = 0; i < 32; i++) work[i] = mat_rows[i] & keep;
        rank = 0;
        for (int unsigned c = 0; c < q && rank < m; c++) begin
            r = rank;
            while (r < m && !work[r][31 - c]) r++;
            if (r < m) begin
                tmp        = work[r];
                work[r]    = work[rank];
                work[rank] = tmp;
                for (int unsigned i = 0; i < m; i++)
                    if (i != rank && work[i][31 - c]) work[i] ^= work[rank];
                rank++;
            end
        end
        return rank;
    endfunction

    // One accepted item: place it, and on a full matrix queue the result
    function automatic void absorb_stream_item(logic bit_in, logic [31:0] word_in);
        int unsigned  m;
        int unsigned  q;
        int unsigned  rank;
        logic         full;
        t_rank_result res;
        m    = eff_rows();
        q    = eff_cols();
        full = 1'b0;
        if (mat_done >= cfg_goal) return;   // goal reached: dropped
        if (row_pos >= m || col_pos >= q) begin
            row_pos = 0;
            col_pos = 0;
        end
        if (cfg_word) begin
            mat_rows[5'(row_pos)] = word_in << cfg_shift;
            col_pos = 0;
            row_pos++;
            full = (row_pos >= m);
        end else begin
            // first bit of a row wipes the stale row
            if (col_pos == 0) mat_rows[5'(row_pos)] = '0;
            mat_rows[5'(row_pos)][5'(31 - col_pos)] = bit_in;
            col_pos++;
            if (col_pos >= q) begin
                col_pos = 0;
                row_pos++;
                full = (row_pos >= m);
            end
        end
        if (!full) return;
        row_pos = 0;
        col_pos = 0;
        rank = gf2_rank_of(m, q);
        if (rank_hist[6'(rank)] != '1) rank_hist[6'(rank)]++;   // saturating
        if (mat_done != '1) mat_done++;
        res.rank  = rank[RANK_OUT_W-1:0];
        res.tally = rank_hist[6'(rank)];
        res.done  = mat_done;
        res.goal  = (mat_done == cfg_goal);
        matrix_outcomes.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[binary_matrix_rank_histogram_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input driver: offers backlog items, holds valid until accepted,
    // idles at random between items. Prediction happens on acceptance.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : tx_drive
        t_stream_item nxt;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                absorb_stream_item(in_bus.stream_bit, in_bus.stream_word);
                void'(stream_backlog.pop_front());
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (stream_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = stream_backlog[0];
                    in_bus.valid       <= 1'b1;
                    in_bus.stream_bit  <= nxt.bit_in;
                    in_bus.stream_word <= nxt.word_in;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: compares each accepted item with the oldest
    // prediction; drives ready with random stalls and the hold-off.
    // ------------------------------------------------------------------
    function automatic void check_field(string what, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : rx_check
        t_rank_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (matrix_outcomes.size() == 0) begin
                $display("%0t: result expected none, got rank %0d tally %0d done %0d goal %0d",
                         $time, out_bus.matrix_rank, out_bus.rank_tally,
                         out_bus.matrices_done, out_bus.goal_reached);
                mismatches++;
            end else begin
                want = matrix_outcomes.pop_front();
                check_field("matrix_rank", 24'(want.rank), 24'(out_bus.matrix_rank));
                check_field("rank_tally", want.tally, out_bus.rank_tally);
                check_field("matrices_done", want.done, out_bus.matrices_done);
                check_field("goal_reached", 24'(want.goal), 24'(out_bus.goal_reached));
            end
        end
        out_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end

    // Long receiver hold-off, counted here so the block backs up
    always @(posedge i_clk) begin : rx_hold
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void offer(logic bit_in, logic [31:0] word_in);
        t_stream_item it;
        it.bit_in  = bit_in;
        it.word_in = word_in;
        stream_backlog.push_back(it);
    endfunction

    // Mix of dense, low-rank and degenerate rows
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        int unsigned k;
        k = $urandom_range(99);
        if (k < 40) begin
            w = $urandom();
        end else if (k < 70) begin
            w = '0;
            for (int j = 0; j < 4; j++)
                if ($urandom_range(1)) w ^= word_basis[j];
        end else if (k < 80) begin
            w = '0;
        end else if (k < 90) begin
            w = '1;
        end else begin
            w = 32'h1 << $urandom_range(31);
        end
        return w;
    endfunction

    // Register write; the block is idle, so the shadow copy updates at once
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_ROW_COUNT: begin
                cfg_rows = val[GEO_W-1:0];
                row_pos  = 0;
                col_pos  = 0;
            end
            CFG_COL_COUNT: begin
                cfg_cols = val[GEO_W-1:0];
                row_pos  = 0;
                col_pos  = 0;
            end
            CFG_WORD_MODE: begin
                cfg_word = val[0];
                row_pos  = 0;
                col_pos  = 0;
            end
            CFG_WORD_SHIFT:  cfg_shift = val[SHIFT_W-1:0];
            CFG_MATRIX_GOAL: cfg_goal  = val[GOAL_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // idle modes: 0 none, 1 sender 80%, 2 receiver 80%, 3 both 10%
    task automatic set_idling(int mode);
        case (mode)
            1:       begin tx_idle_pct <= 80; rx_stall_pct <= 0;  end
            2:       begin tx_idle_pct <= 0;  rx_stall_pct <= 80; end
            3:       begin tx_idle_pct <= 10; rx_stall_pct <= 10; end
            default: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
        endcase
    endtask

    // Wait until every item is in and every result is out, then let any
    // trailing reduction finish before touching config.
    task automatic settle();
        while (stream_backlog.size() != 0 || matrix_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned n_items;
        logic        b;
        predictor_reset();
        mismatches         = 0;
        cycle_count        = 0;
        hold_start         = 1'b0;
        hold_left          = 0;
        tx_idle_pct        = 0;
        rx_stall_pct       = 0;
        bit_bias           = 50;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        in_bus.valid       = 1'b0;
        in_bus.stream_bit  = 1'b0;
        in_bus.stream_word = '0;
        out_bus.ready      = 1'b0;
        for (int j = 0; j < 4; j++) word_basis[j] = $urandom();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part -------------------------------------------
        set_idling(0);
        write_reg(CFG_MATRIX_GOAL, 24'hFF_FFFF);

        // zero rows / zero columns act as a 1x1 matrix: rank 1 then 0
        write_reg(CFG_ROW_COUNT, 0);
        write_reg(CFG_COL_COUNT, 0);
        offer(1'b1, 32'h0);
        offer(1'b0, 32'hFFFF_FFFF);
        settle();

        // 2x2 bit mode: identity, then all ones
        write_reg(CFG_ROW_COUNT, 2);
        write_reg(CFG_COL_COUNT, 2);
        offer(1, 0); offer(0, 0); offer(0, 0); offer(1, 0);
        offer(1, 0); offer(1, 0); offer(1, 0); offer(1, 0);
        settle();

        // geometry change mid-matrix throws the partial matrix away
        offer(1, 0); offer(1, 0);
        settle();
        write_reg(CFG_COL_COUNT, 3);
        offer(1, 0); offer(0, 0); offer(0, 0);
        offer(0, 0); offer(1, 0); offer(0, 0);
        settle();

        // word mode, full width rows; all ones over zero -> rank 1
        write_reg(CFG_WORD_MODE, 1);
        write_reg(CFG_COL_COUNT, 32);
        write_reg(CFG_WORD_SHIFT, 0);
        offer(0, 32'hFFFF_FFFF);
        offer(1, 32'h0000_0000);
        settle();

        // shift change mid-matrix keeps the partial matrix; bit 0 moves
        // to the top, bits past 31 are lost
        offer(1, 32'h8000_0000);
        settle();
        write_reg(CFG_WORD_SHIFT, 31);
        offer(0, 32'h0000_0001);
        settle();

        // goal reached on the next matrix, then input is dropped
        write_reg(CFG_MATRIX_GOAL, CFG_DATA_W'(mat_done + 24'd1));
        offer(0, 32'h1234_5678); offer(1, 32'h8765_4321);
        offer(0, 32'hDEAD_BEEF); offer(1, 32'h0F0F_0F0F);
        settle();

        // goal of zero: everything is dropped
        write_reg(CFG_MATRIX_GOAL, 0);
        offer(1, 32'hFFFF_FFFF);
        settle();

        // --- random part ---------------------------------------------
        for (int p = 0; p < NUM_PHASES; p++) begin
            for (int j = 0; j < 4; j++) word_basis[j] = $urandom();
            bit_bias = $urandom_range(90, 10);
            write_reg(CFG_MATRIX_GOAL, 24'hFF_FFFF);
            case (p)
                0: begin
                    write_reg(CFG_WORD_MODE, 1);
                    write_reg(CFG_ROW_COUNT, 32);
                    write_reg(CFG_COL_COUNT, 32);
                    write_reg(CFG_WORD_SHIFT, 0);
                end
                1: begin
                    write_reg(CFG_WORD_MODE, 0);
                    write_reg(CFG_ROW_COUNT, 3);
                    write_reg(CFG_COL_COUNT, 4);
                end
                2: begin
                    // out of range geometry clamps to 32 x 32
                    write_reg(CFG_WORD_MODE, 1);
                    write_reg(CFG_ROW_COUNT, 40);
                    write_reg(CFG_COL_COUNT, 63);
                    write_reg(CFG_WORD_SHIFT, CFG_DATA_W'($urandom_range(31)));
                end
                3: begin
                    write_reg(CFG_WORD_MODE, 0);
                    write_reg(CFG_ROW_COUNT, 1);
                    write_reg(CFG_COL_COUNT, 32);
                end
                4: begin
                    write_reg(CFG_WORD_MODE, 1);
                    write_reg(CFG_ROW_COUNT, CFG_DATA_W'($urandom_range(8, 1)));
                    write_reg(CFG_COL_COUNT, CFG_DATA_W'($urandom_range(32, 1)));
                    write_reg(CFG_WORD_SHIFT, CFG_DATA_W'($urandom_range(31)));
                end
                5: begin
                    write_reg(CFG_WORD_MODE, 0);
                    write_reg(CFG_ROW_COUNT, 2);
                    write_reg(CFG_COL_COUNT, 2);
                end
                6: begin
                    // 1x1 word matrices; goal hit partway, rest dropped
                    write_reg(CFG_WORD_MODE, 1);
                    write_reg(CFG_ROW_COUNT, 0);
                    write_reg(CFG_COL_COUNT, 0);
                    write_reg(CFG_WORD_SHIFT, CFG_DATA_W'($urandom_range(31)));
                    write_reg(CFG_MATRIX_GOAL, CFG_DATA_W'(mat_done + 24'd60));
                end
                7: begin
                    write_reg(CFG_WORD_MODE, 0);
                    write_reg(CFG_ROW_COUNT, CFG_DATA_W'($urandom_range(5, 1)));
                    write_reg(CFG_COL_COUNT, CFG_DATA_W'($urandom_range(6, 1)));
                    write_reg(CFG_WORD_SHIFT, 31);   // no effect in bit mode
                end
                default: begin
                    write_reg(CFG_WORD_MODE, 1);
                    write_reg(CFG_ROW_COUNT, CFG_DATA_W'($urandom_range(32, 1)));
                    write_reg(CFG_COL_COUNT, 1);
                    write_reg(CFG_WORD_SHIFT, CFG_DATA_W'($urandom_range(31)));
                end
            endcase
            set_idling(p % 4);

            n_items = PHASE_ITEMS;
            for (int k = 0; k < n_items; k++) begin
                b = ($urandom_range(99) < bit_bias);
                if (cfg_word) offer(b, pick_word());
                else          offer(b, $urandom());
            end

            // back-pressure: receiver stops while the sender keeps going
            if (p == 4) begin
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            settle();
        end

        if (mismatches == 0 && matrix_outcomes.size() == 0) begin
            $display("[binary_matrix_rank_histogram_unit] OK");
        end else begin
            $display("[binary_matrix_rank_histogram_unit] ERROR");
        end
        $finish;
    end

endmodule
